// ===== src/fit_policy_segment_allocator_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the segment allocator
// Shared concurrent check forms used by the controller.
// ---------------------------------------------------------------------------
`ifndef FIT_POLICY_SEGMENT_ALLOCATOR_UNIT_MACROS_SVH
`define FIT_POLICY_SEGMENT_ALLOCATOR_UNIT_MACROS_SVH

// implication check under synchronous reset
`define FPSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check under synchronous reset
`define FPSA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fpsa_pkg.sv =====
// ---------------------------------------------------------------------------
// Segment allocator package
// Shared payload types, codes and controller states.
// ---------------------------------------------------------------------------
package fpsa_pkg;

  localparam int AddrWidth = 16;
  localparam int IdWidth   = 8;
  localparam int SizeWidth = AddrWidth + 1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_WORST = 2'd1,
    POL_BEST  = 2'd2,
    POL_SPARE = 2'd3
  } policy_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [0:0] CFG_MEM_SIZE = 1'b0;
  localparam logic [0:0] CFG_POLICY   = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [IdWidth-1:0]   block_id;
    logic [SizeWidth-1:0] request_size;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [AddrWidth-1:0] start_addr;
    logic [AddrWidth-1:0] end_addr;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_REMOVE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic shift_up;
    logic shift_down;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic is_free;
    logic early_done;
    logic shift_last;
  } sts_t;

endpackage

// ===== src/fpsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// Segment allocator controller
// Sequences load, table scan, shift and result phases.
// ---------------------------------------------------------------------------
`include "fit_policy_segment_allocator_unit_macros.svh"

module fpsa_ctrl
  import fpsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.early_done) state_next = S_DONE;
        else if (sts.scan_last) begin
          if (!sts.found) state_next = S_DONE;
          else if (sts.is_free) state_next = S_REMOVE;
          else state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        if (sts.shift_last) state_next = S_DONE;
      end
      S_REMOVE: begin
        if (sts.shift_last) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:   cmd.load = start;
      S_SCAN:   cmd.scan = 1'b1;
      S_INSERT: cmd.shift_up = 1'b1;
      S_REMOVE: cmd.shift_down = 1'b1;
      S_DONE:   cmd.finish = 1'b1;
      default:  cmd = '0;
    endcase
  end

  `FPSA_ASSERT_NXT(a_load_scans, clk, rst, cmd.load, state == S_SCAN, "load not followed by scan")
  `FPSA_ASSERT_NXT(a_done_idle, clk, rst, cmd.finish, !busy, "finish not followed by idle")
  `FPSA_ASSERT_IMP(a_onecmd, clk, rst, 1'b1, $onehot0(cmd), "multiple commands")

endmodule

// ===== src/fpsa_datapath.sv =====
// ---------------------------------------------------------------------------
// Segment allocator datapath
// Segment table, hole scanner, shifter and result register.
// ---------------------------------------------------------------------------
module fpsa_datapath
  import fpsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  req_t                  req,
  input  logic [SizeWidth-1:0]  memory_size,
  input  policy_t               fit_policy,
  output sts_t                  sts,
  output logic                  done,
  output rsp_t                  rsp
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int HW = AddrWidth + 1;

  logic [IdWidth-1:0]    seg_ident [MAX_SEGMENTS];
  logic [AddrWidth-1:0]  seg_first [MAX_SEGMENTS];
  logic [AddrWidth-1:0]  seg_last  [MAX_SEGMENTS];

  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         pick;
  logic                  found;
  logic [HW-1:0]         pick_hole;
  logic [AddrWidth-1:0]  pick_start;
  logic [AddrWidth-1:0]  hit_first, hit_last;
  logic                  is_free;
  logic [IdWidth-1:0]    id;
  logic [SizeWidth-1:0]  want;
  logic [HW-1:0]         lim;
  logic                  early;
  logic [1:0]            early_code;

  logic [HW:0]           prev_end1;
  logic [HW-1:0]         next_start;
  logic [HW:0]           hole;
  logic                  fits, better;
  logic [IW-1:0]         ii, im1;

  always_comb begin
    lim = (memory_size > SizeWidth'(1 << AddrWidth)) ? HW'(1 << AddrWidth)
                                                      : HW'(memory_size);
  end

  assign ii  = idx[IW-1:0];
  assign im1 = IW'(idx - CW'(1));

  always_comb begin
    prev_end1 = (idx == '0) ? '0 : {1'b0, 1'b0, seg_last[im1]} + (HW+1)'(1);
    next_start = (idx == count) ? lim : {1'b0, seg_first[ii]};
    if (next_start > lim) next_start = lim;
    hole = ({1'b0, next_start} >= prev_end1) ? ({1'b0, next_start} - prev_end1) : '0;
    fits = ({1'b0, next_start} >= prev_end1) && (hole >= (HW+1)'(want));
    better = !found ||
             (fit_policy == POL_WORST && hole[HW-1:0] > pick_hole) ||
             (fit_policy == POL_BEST  && hole[HW-1:0] < pick_hole);
  end

  logic first_policy;
  assign first_policy = (fit_policy != POL_WORST) && (fit_policy != POL_BEST);

  logic scan_last;
  always_comb begin
    if (is_free) scan_last = (idx >= count) || (found);
    else scan_last = (idx > count) || (found && first_policy);
  end

  logic shift_last;
  always_comb begin
    if (is_free) shift_last = (idx + CW'(1) >= count);
    else shift_last = (idx <= pick);
  end

  assign sts.scan_last  = scan_last;
  assign sts.found      = found;
  assign sts.is_free    = is_free;
  assign sts.early_done = early;
  assign sts.shift_last = shift_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        is_free <= req.req_type;
        id      <= req.block_id;
        want    <= req.request_size;
        idx     <= '0;
        found   <= 1'b0;
        early   <= 1'b0;
        if (req.req_type == REQ_ALLOC && req.request_size == '0) begin
          early <= 1'b1; early_code <= ST_NO_FIT;
        end else if (req.req_type == REQ_ALLOC && count == CW'(MAX_SEGMENTS)) begin
          early <= 1'b1; early_code <= ST_FULL;
        end
      end else if (cmd.scan && !early) begin
        if (is_free) begin
          if (idx < count && !found) begin
            if (seg_ident[ii] == id) begin
              found <= 1'b1; pick <= idx;
              hit_first <= seg_first[ii]; hit_last <= seg_last[ii];
            end else idx <= idx + CW'(1);
          end
        end else if (scan_last) begin
          idx <= count;
        end else begin
          if (fits && better) begin
            found <= 1'b1; pick <= idx;
            pick_hole <= hole[HW-1:0];
            pick_start <= prev_end1[AddrWidth-1:0];
          end
          idx <= idx + CW'(1);
        end
      end else if (cmd.shift_up) begin
        if (idx > pick) begin
          seg_ident[ii] <= seg_ident[im1];
          seg_first[ii] <= seg_first[im1];
          seg_last[ii]  <= seg_last[im1];
          idx <= idx - CW'(1);
        end else begin
          seg_ident[pick[IW-1:0]] <= id;
          seg_first[pick[IW-1:0]] <= pick_start;
          seg_last[pick[IW-1:0]]  <= AddrWidth'(pick_start + want[AddrWidth-1:0] - 1'b1);
          hit_first <= pick_start;
          hit_last  <= AddrWidth'(pick_start + want[AddrWidth-1:0] - 1'b1);
          count <= count + CW'(1);
        end
      end else if (cmd.shift_down) begin
        if (idx + CW'(1) < count) begin
          seg_ident[ii] <= seg_ident[IW'(idx + CW'(1))];
          seg_first[ii] <= seg_first[IW'(idx + CW'(1))];
          seg_last[ii]  <= seg_last[IW'(idx + CW'(1))];
          idx <= idx + CW'(1);
        end else begin
          count <= count - CW'(1);
        end
      end
      if (cmd.finish) begin
        if (early) rsp <= '{early_code, '0, '0};
        else if (!found) rsp <= '{(is_free ? ST_NOT_FOUND : ST_NO_FIT), '0, '0};
        else rsp <= '{ST_OK, hit_first, hit_last};
      end
    end
  end

endmodule

// ===== src/fit_policy_segment_allocator_unit.sv =====
// ---------------------------------------------------------------------------
// Segment allocator top level
// Scan and shift phases move one table entry per cycle; a new request is taken
// only while busy is low, once the previous request has finished.
// busy falls with the done strobe, so the next request can start in that cycle.
// The receiver cannot stall; configuration writes are always ready.
// Synchronous active-high rst empties the table, memory_size 65536, first fit.
// ---------------------------------------------------------------------------
module fit_policy_segment_allocator_unit
  import fpsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        request,
  output logic        done,
  output rsp_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  logic [SizeWidth-1:0] memory_size;
  policy_t              fit_policy;
  cmd_t                 cmd;
  sts_t                 sts;
  logic                 ctrl_busy;

  assign cfg_ready = 1'b1;
  assign busy      = ctrl_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_size <= SizeWidth'(65536);
      fit_policy  <= POL_FIRST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MEM_SIZE: memory_size <= cfg_data;
        CFG_POLICY:   fit_policy  <= policy_t'(cfg_data[1:0]);
        default:      memory_size <= memory_size;
      endcase
    end
  end

  fpsa_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .busy (ctrl_busy),
    .cmd  (cmd)
  );

  fpsa_datapath #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req        (request),
    .memory_size(memory_size),
    .fit_policy (fit_policy),
    .sts        (sts),
    .done       (done),
    .rsp        (result)
  );

endmodule
